/* hw/rtl/mcb_pkg.sv */
// shared types, constants and codes of the modbus coil bank slave
package mcb_pkg;

  localparam int DEF_NUM_COILS   = 64;
  localparam int DEF_NUM_INPUTS  = 64;
  localparam int DEF_STAGE_DEPTH = 8;

  localparam int BODY_MAX = 11;

  localparam logic [15:0] MAX_READ_COUNT  = 16'd2000;
  localparam logic [15:0] MAX_WRITE_COUNT = 16'd1968;
  localparam logic [15:0] COIL_ON         = 16'hFF00;
  localparam logic [15:0] COIL_OFF        = 16'h0000;
  localparam logic [8:0]  POS_MAX         = 9'd511;
  localparam logic [15:0] CRC_INIT        = 16'hFFFF;
  localparam logic [15:0] CRC_POLY        = 16'hA001;

  localparam logic [7:0] FC_READ_COILS  = 8'd1;
  localparam logic [7:0] FC_READ_INPUTS = 8'd2;
  localparam logic [7:0] FC_WRITE_ONE   = 8'd5;
  localparam logic [7:0] FC_WRITE_MANY  = 8'd15;
  localparam logic [7:0] FC_EXC_FLAG    = 8'h80;

  localparam logic [7:0] EX_ADDRESS = 8'd2;
  localparam logic [7:0] EX_VALUE   = 8'd3;
  localparam logic [7:0] EX_FAILURE = 8'd4;

  typedef enum logic [1:0] {
    REG_SLAVE_ADDR,
    REG_COIL_COUNT,
    REG_INPUT_COUNT,
    REG_WRITE_PROTECT
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_LOAD,
    ST_SHIFT,
    ST_SEND,
    ST_CRC_LO,
    ST_CRC_HI
  } state_t;

  typedef struct packed {
    logic init;
    logic load;
    logic step;
  } crc_ctl_t;

endpackage

/* hw/rtl/mcb_if.sv */
// request and response byte channels
interface mcb_req_if;
  logic        valid;
  logic        ready;
  logic [7:0]  rx_byte;
  logic        frame_end;
  logic [63:0] discrete_inputs;
  modport source (output valid, rx_byte, frame_end, discrete_inputs, input ready);
  modport sink (input valid, rx_byte, frame_end, discrete_inputs, output ready);
endinterface

interface mcb_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] tx_byte;
  logic       tx_last;
  modport source (output valid, tx_byte, tx_last, input ready);
  modport sink (input valid, tx_byte, tx_last, output ready);
endinterface

/* hw/rtl/mcb_crc_unit.sv */
// bit-serial modbus crc-16 unit, one shift per cycle
module mcb_crc_unit import mcb_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  crc_ctl_t    ctl,
  input  logic [7:0]  data,
  output logic [15:0] crc
);

  logic [15:0] crc_r, crc_nxt;

  always_comb begin
    crc_nxt = crc_r;
    priority if (ctl.init) begin
      crc_nxt = CRC_INIT;
    end else if (ctl.load) begin
      crc_nxt = crc_r ^ {8'h00, data};
    end else if (ctl.step) begin
      crc_nxt = crc_r[0] ? ((crc_r >> 1) ^ CRC_POLY) : (crc_r >> 1);
    end else begin
      crc_nxt = crc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r <= CRC_INIT;
    end else begin
      crc_r <= crc_nxt;
    end
  end

  assign crc = crc_r;

endmodule

/* hw/rtl/modbus_coil_bank_slave.sv */
// modbus rtu slave serving coil functions 1, 2, 5 and 15
// the final request byte is decoded in the cycle after it is taken; each body byte of
// the response then passes through the bit-serial crc unit (a load, then one shift per
// bit) before it is offered; the two crc bytes follow the last body byte, and each byte
// waits while the output stalls
// throughput: one request byte per cycle while idle; no input during decode and reply
// reset (synchronous, active low): coils cleared, registers to defaults, crc to 0xffff
module modbus_coil_bank_slave import mcb_pkg::*; #(
  parameter int NUM_COILS   = DEF_NUM_COILS,
  parameter int NUM_INPUTS  = DEF_NUM_INPUTS,
  parameter int STAGE_DEPTH = DEF_STAGE_DEPTH
) (
  input  logic         clk,
  input  logic         rst_n,
  mcb_req_if.sink      in_if,
  mcb_rsp_if.source    out_if,
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [4:0]   cfg_paddr,
  input  logic [63:0]  cfg_pwdata,
  output logic [63:0]  cfg_prdata,
  output logic         cfg_pready
);

  localparam int SW = (STAGE_DEPTH > 1) ? $clog2(STAGE_DEPTH) : 1;

  // configuration
  logic [7:0]  slave_addr_r;
  logic [6:0]  coil_count_r;
  logic [6:0]  input_count_r;
  logic [63:0] wprot_r;
  logic        cfg_wr;
  reg_idx_t    cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_idx    = reg_idx_t'(cfg_paddr[4:3]);

  always_comb begin
    unique case (cfg_idx)
      REG_SLAVE_ADDR:    cfg_prdata = 64'(slave_addr_r);
      REG_COIL_COUNT:    cfg_prdata = 64'(coil_count_r);
      REG_INPUT_COUNT:   cfg_prdata = 64'(input_count_r);
      REG_WRITE_PROTECT: cfg_prdata = wprot_r;
      default:           cfg_prdata = 64'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slave_addr_r  <= 8'd1;
      coil_count_r  <= 7'd64;
      input_count_r <= 7'd64;
      wprot_r       <= 64'd0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_SLAVE_ADDR:    slave_addr_r  <= cfg_pwdata[7:0];
        REG_COIL_COUNT:    coil_count_r  <= cfg_pwdata[6:0];
        REG_INPUT_COUNT:   input_count_r <= cfg_pwdata[6:0];
        REG_WRITE_PROTECT: wprot_r       <= cfg_pwdata;
        default:           ;
      endcase
    end
  end

  // request capture and control state
  state_t          state_r, state_nxt;
  logic [8:0]      pos_r, pos_nxt;
  logic [8:0]      len_r, len_nxt;
  logic [7:0]      slave_r, slave_nxt;
  logic [7:0]      code_r, code_nxt;
  logic [15:0]     start_r, start_nxt;
  logic [15:0]     amount_r, amount_nxt;
  logic [7:0]      dlen_r, dlen_nxt;
  logic [63:0]     dins_r, dins_nxt;
  logic [7:0]      stage_r [STAGE_DEPTH];
  logic [NUM_COILS-1:0] coil_r, coil_nxt;
  logic [7:0]      body_r [BODY_MAX];
  logic [7:0]      body_nxt [BODY_MAX];
  logic [3:0]      body_n_r, body_n_nxt;
  logic [3:0]      idx_r, idx_nxt;
  logic [2:0]      bit_r, bit_nxt;
  logic            in_acc, out_acc;
  logic [8:0]      len_now;
  logic            stage_we;
  logic [SW-1:0]   stage_wa;
  crc_ctl_t        crc_ctl;
  logic [15:0]     crc;

  assign in_acc  = in_if.valid && in_if.ready;
  assign out_acc = out_if.valid && out_if.ready;
  assign len_now = (pos_r < POS_MAX) ? pos_r + 9'd1 : POS_MAX;
  assign stage_we = in_acc && (pos_r >= 9'd7) && ((pos_r - 9'd7) < 9'(STAGE_DEPTH));
  assign stage_wa = SW'(pos_r - 9'd7);

  always_ff @(posedge clk) begin
    if (stage_we) begin
      stage_r[stage_wa] <= in_if.rx_byte;
    end
  end

  // decode
  logic [6:0]  tbl_c, tbl_i, tbl;
  logic [16:0] span_end;
  logic        bcast, range_bad, range_bad_c;
  logic [63:0] coil64, src, n_mask, w_mask, sdata, rbits, coil_new;
  logic [3:0]  nbytes;
  logic [16:0] amt_bytes;
  logic [8:0]  want_len;
  logic        respond, is_exc, do_apply;
  logic [7:0]  exc_code;

  always_comb begin
    tbl_c  = (coil_count_r > 7'(NUM_COILS)) ? 7'(NUM_COILS) : coil_count_r;
    tbl_i  = (input_count_r > 7'(NUM_INPUTS)) ? 7'(NUM_INPUTS) : input_count_r;
    tbl    = (code_r == FC_READ_COILS) ? tbl_c : tbl_i;
    span_end = 17'(start_r) + 17'(amount_r);
    range_bad = (tbl == 7'd0) || (start_r >= 16'(tbl)) || (span_end > 17'(tbl));
    range_bad_c = (tbl_c == 7'd0) || (start_r >= 16'(tbl_c)) || (span_end > 17'(tbl_c));
    bcast  = (slave_r == 8'd0);
    coil64 = 64'(coil_r);
    src    = (code_r == FC_READ_COILS) ? coil64 : dins_r;
    n_mask = (amount_r >= 16'd64) ? '1 : ((64'd1 << amount_r[5:0]) - 64'd1);
    w_mask = n_mask << start_r[5:0];
    rbits  = (src >> start_r[5:0]) & n_mask;
    amt_bytes = (17'(amount_r) + 17'd7) >> 3;
    nbytes = amt_bytes[3:0];
    want_len = 9'd9 + 9'(dlen_r);
    sdata  = 64'd0;
    for (int i = 0; i < 8; i++) begin
      if (i < STAGE_DEPTH) begin
        sdata[8*i +: 8] = stage_r[i];
      end
    end
    respond  = 1'b0;
    is_exc   = 1'b0;
    do_apply = 1'b0;
    exc_code = EX_VALUE;
    coil_new = coil64;
    if ((code_r == FC_READ_COILS) || (code_r == FC_READ_INPUTS)) begin
      if (!bcast) begin
        respond = 1'b1;
        is_exc  = 1'b1;
        priority if (len_r != 9'd8) begin
          exc_code = EX_VALUE;
        end else if ((amount_r == 16'd0) || (amount_r > MAX_READ_COUNT)) begin
          exc_code = EX_VALUE;
        end else if (range_bad) begin
          exc_code = EX_ADDRESS;
        end else begin
          is_exc = 1'b0;
        end
      end
    end else if (code_r == FC_WRITE_ONE) begin
      respond = !bcast;
      is_exc  = 1'b1;
      priority if (len_r != 9'd8) begin
        exc_code = EX_VALUE;
      end else if ((amount_r != COIL_ON) && (amount_r != COIL_OFF)) begin
        exc_code = EX_VALUE;
      end else if ((tbl_c == 7'd0) || (start_r >= 16'(tbl_c))) begin
        exc_code = EX_ADDRESS;
      end else if (wprot_r[start_r[5:0]]) begin
        exc_code = EX_FAILURE;
      end else begin
        is_exc   = 1'b0;
        do_apply = 1'b1;
        coil_new[start_r[5:0]] = (amount_r == COIL_ON);
      end
    end else if (code_r == FC_WRITE_MANY) begin
      respond = !bcast;
      is_exc  = 1'b1;
      priority if ((len_r < 9'd7) || (len_r != want_len)) begin
        exc_code = EX_VALUE;
      end else if ((dlen_r == 8'd0) || (amount_r == 16'd0) ||
                   (amt_bytes != 17'(dlen_r)) || (amount_r > MAX_WRITE_COUNT)) begin
        exc_code = EX_VALUE;
      end else if (range_bad_c) begin
        exc_code = EX_ADDRESS;
      end else if ((wprot_r & w_mask) != 64'd0) begin
        exc_code = EX_FAILURE;
      end else begin
        is_exc   = 1'b0;
        do_apply = 1'b1;
        coil_new = (coil64 & ~w_mask) | ((sdata << start_r[5:0]) & w_mask);
      end
    end
  end

  // datapath next values
  always_comb begin
    pos_nxt    = pos_r;
    len_nxt    = len_r;
    slave_nxt  = slave_r;
    code_nxt   = code_r;
    start_nxt  = start_r;
    amount_nxt = amount_r;
    dlen_nxt   = dlen_r;
    dins_nxt   = dins_r;
    coil_nxt   = coil_r;
    body_n_nxt = body_n_r;
    idx_nxt    = idx_r;
    bit_nxt    = bit_r;
    for (int i = 0; i < BODY_MAX; i++) begin
      body_nxt[i] = body_r[i];
    end
    if (in_acc) begin
      unique case (pos_r)
        9'd0:    slave_nxt  = in_if.rx_byte;
        9'd1:    code_nxt   = in_if.rx_byte;
        9'd2:    start_nxt  = {in_if.rx_byte, start_r[7:0]};
        9'd3:    start_nxt  = {start_r[15:8], in_if.rx_byte};
        9'd4:    amount_nxt = {in_if.rx_byte, amount_r[7:0]};
        9'd5:    amount_nxt = {amount_r[15:8], in_if.rx_byte};
        9'd6:    dlen_nxt   = in_if.rx_byte;
        default: ;
      endcase
      pos_nxt = in_if.frame_end ? 9'd0 : len_now;
      len_nxt = len_now;
      dins_nxt = in_if.discrete_inputs;
    end
    if (state_r == ST_DECODE) begin
      idx_nxt = 4'd0;
      if (do_apply) begin
        coil_nxt = coil_new[NUM_COILS-1:0];
      end
      body_nxt[0] = slave_addr_r;
      if (is_exc) begin
        body_nxt[1] = code_r | FC_EXC_FLAG;
        body_nxt[2] = exc_code;
        body_n_nxt  = 4'd3;
      end else if ((code_r == FC_READ_COILS) || (code_r == FC_READ_INPUTS)) begin
        body_nxt[1] = code_r;
        body_nxt[2] = {4'd0, nbytes};
        for (int i = 0; i < 8; i++) begin
          body_nxt[3+i] = rbits[8*i +: 8];
        end
        body_n_nxt = 4'd3 + nbytes;
      end else begin
        body_nxt[1] = code_r;
        body_nxt[2] = start_r[15:8];
        body_nxt[3] = start_r[7:0];
        body_nxt[4] = amount_r[15:8];
        body_nxt[5] = amount_r[7:0];
        body_n_nxt  = 4'd6;
      end
    end
    if (state_r == ST_LOAD) begin
      bit_nxt = 3'd0;
    end
    if (state_r == ST_SHIFT) begin
      bit_nxt = bit_r + 3'd1;
    end
    if ((state_r == ST_SEND) && out_acc) begin
      idx_nxt = idx_r + 4'd1;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && in_if.frame_end && (len_now >= 9'd4) &&
            ((slave_r == 8'd0) || (slave_r == slave_addr_r))) begin
          state_nxt = ST_DECODE;
        end
      end
      ST_DECODE: state_nxt = respond ? ST_LOAD : ST_IDLE;
      ST_LOAD:   state_nxt = ST_SHIFT;
      ST_SHIFT:  if (bit_r == 3'd7) state_nxt = ST_SEND;
      ST_SEND: begin
        if (out_acc) begin
          state_nxt = (idx_r + 4'd1 == body_n_r) ? ST_CRC_LO : ST_LOAD;
        end
      end
      ST_CRC_LO: if (out_acc) state_nxt = ST_CRC_HI;
      ST_CRC_HI: if (out_acc) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_if.ready    = 1'b0;
    out_if.valid   = 1'b0;
    out_if.tx_byte = body_r[idx_r];
    out_if.tx_last = 1'b0;
    crc_ctl        = '0;
    unique case (state_r)
      ST_IDLE:   in_if.ready = 1'b1;
      ST_DECODE: crc_ctl.init = 1'b1;
      ST_LOAD:   crc_ctl.load = 1'b1;
      ST_SHIFT:  crc_ctl.step = 1'b1;
      ST_SEND:   out_if.valid = 1'b1;
      ST_CRC_LO: begin
        out_if.valid   = 1'b1;
        out_if.tx_byte = crc[7:0];
      end
      ST_CRC_HI: begin
        out_if.valid   = 1'b1;
        out_if.tx_byte = crc[15:8];
        out_if.tx_last = 1'b1;
      end
      default: ;
    endcase
  end

  mcb_crc_unit u_crc (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (crc_ctl),
    .data  (body_r[idx_r]),
    .crc   (crc)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      pos_r    <= 9'd0;
      len_r    <= 9'd0;
      slave_r  <= 8'd0;
      code_r   <= 8'd0;
      start_r  <= 16'd0;
      amount_r <= 16'd0;
      dlen_r   <= 8'd0;
      coil_r   <= '0;
      body_n_r <= 4'd0;
      idx_r    <= 4'd0;
      bit_r    <= 3'd0;
    end else begin
      state_r  <= state_nxt;
      pos_r    <= pos_nxt;
      len_r    <= len_nxt;
      slave_r  <= slave_nxt;
      code_r   <= code_nxt;
      start_r  <= start_nxt;
      amount_r <= amount_nxt;
      dlen_r   <= dlen_nxt;
      coil_r   <= coil_nxt;
      body_n_r <= body_n_nxt;
      idx_r    <= idx_nxt;
      bit_r    <= bit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dins_r <= dins_nxt;
    for (int i = 0; i < BODY_MAX; i++) begin
      body_r[i] <= body_nxt[i];
    end
  end

endmodule

/* hw/rtl/mcb_checker.sv */
// port-level checks of the modbus coil bank slave and their binding
module mcb_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       frame_end,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] tx_byte,
  input logic       tx_last
);

  logic in_acc, out_acc;
  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> !out_valid) else $error("request taken while response pending");

  a_quiet_midframe: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && !frame_end |=> !out_valid) else $error("response before frame end");

  a_end_of_reply: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc && tx_last |=> !out_valid) else $error("bytes after last response byte");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(tx_byte) && $stable(tx_last))
    else $error("stalled response byte changed");

endmodule

bind modbus_coil_bank_slave mcb_checker u_mcb_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_if.valid),
  .in_ready  (in_if.ready),
  .frame_end (in_if.frame_end),
  .out_valid (out_if.valid),
  .out_ready (out_if.ready),
  .tx_byte   (out_if.tx_byte),
  .tx_last   (out_if.tx_last)
);

/* sim/tb_modbus_coil_bank_slave.sv */
// testbench for the modbus coil bank slave: directed and random request frames
`timescale 1ns / 100ps

module tb_modbus_coil_bank_slave;
  import mcb_pkg::*;

  typedef logic [7:0] byte_t;
  typedef byte_t byte_q_t[$];
  typedef struct {
    byte_t data;
    logic  last;
  } rsp_byte_t;

  localparam int CYCLE_LIMIT = 600000;
  localparam int SETTLE = 300;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_psel = 1'b0, cfg_penable = 1'b0, cfg_pwrite = 1'b0;
  logic [4:0] cfg_paddr = '0;
  logic [63:0] cfg_pwdata = '0;
  logic [63:0] cfg_prdata;
  logic cfg_pready;

  mcb_req_if req_if ();
  mcb_rsp_if rsp_if ();

  modbus_coil_bank_slave u_dut (
    .clk(clk), .rst_n(rst_n), .in_if(req_if), .out_if(rsp_if),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow of the slave
  byte_t       sh_addr;
  logic [6:0]  sh_coil_cnt, sh_input_cnt;
  logic [63:0] sh_protect;
  logic [63:0] sh_coils;
  logic [8:0]  sh_pos;
  byte_t       sh_slave, sh_code, sh_dlen;
  logic [15:0] sh_start, sh_amt;
  byte_t       sh_stage[8];

  rsp_byte_t expected_rsp[$];
  int errors = 0;
  int cycles = 0;
  int rx_count = 0;
  bit no_idle = 1'b0;

  task automatic report(input string msg);
    $display("mismatch: %s", msg);
    errors++;
  endtask

  function automatic logic [15:0] modbus_crc(input byte_q_t body);
    logic [15:0] c;
    c = CRC_INIT;
    foreach (body[i]) begin
      c ^= {8'h00, body[i]};
      for (int k = 0; k < 8; k++) c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  function automatic void expect_frame(input byte_q_t body);
    logic [15:0] c;
    c = modbus_crc(body);
    foreach (body[i]) expected_rsp.push_back('{body[i], 1'b0});
    expected_rsp.push_back('{c[7:0], 1'b0});
    expected_rsp.push_back('{c[15:8], 1'b1});
  endfunction

  function automatic void expect_exception(input byte_t code);
    if (sh_slave != 8'd0) expect_frame('{sh_addr, sh_code | FC_EXC_FLAG, code});
  endfunction

  function automatic logic [63:0] low_mask(input int n);
    return (n >= 64) ? '1 : ((64'd1 << n) - 64'd1);
  endfunction

  function automatic void predict_read(input int len, input logic [63:0] di);
    int tbl, nb;
    logic [63:0] bits;
    byte_q_t body;
    tbl = (sh_code == FC_READ_COILS) ? ((sh_coil_cnt > 64) ? 64 : sh_coil_cnt)
                                     : ((sh_input_cnt > 64) ? 64 : sh_input_cnt);
    if (sh_slave == 8'd0) return;
    if (len != 8) begin expect_exception(EX_VALUE); return; end
    if (sh_amt == 16'd0 || sh_amt > MAX_READ_COUNT) begin
      expect_exception(EX_VALUE); return;
    end
    if (tbl == 0 || sh_start >= tbl || int'(sh_start) + int'(sh_amt) > tbl) begin
      expect_exception(EX_ADDRESS); return;
    end
    bits = (((sh_code == FC_READ_COILS) ? sh_coils : di) >> sh_start) & low_mask(sh_amt);
    nb = (int'(sh_amt) + 7) / 8;
    body = '{sh_addr, sh_code, byte_t'(nb)};
    for (int k = 0; k < nb && k < 8; k++) body.push_back(bits[8*k +: 8]);
    expect_frame(body);
  endfunction

  function automatic void echo_write();
    if (sh_slave != 8'd0)
      expect_frame('{sh_addr, sh_code, sh_start[15:8], sh_start[7:0],
                     sh_amt[15:8], sh_amt[7:0]});
  endfunction

  function automatic void predict_write_one(input int len);
    int tbl;
    tbl = (sh_coil_cnt > 64) ? 64 : sh_coil_cnt;
    if (len != 8 || (sh_amt != COIL_ON && sh_amt != COIL_OFF)) begin
      expect_exception(EX_VALUE); return;
    end
    if (tbl == 0 || sh_start >= tbl) begin expect_exception(EX_ADDRESS); return; end
    if (sh_protect[sh_start[5:0]]) begin expect_exception(EX_FAILURE); return; end
    sh_coils[sh_start[5:0]] = (sh_amt == COIL_ON);
    echo_write();
  endfunction

  function automatic void predict_write_many(input int len);
    int tbl;
    logic [63:0] m;
    byte_t v;
    tbl = (sh_coil_cnt > 64) ? 64 : sh_coil_cnt;
    if (len < 7 || len != 9 + int'(sh_dlen)) begin expect_exception(EX_VALUE); return; end
    if (sh_dlen == 8'd0 || sh_amt == 16'd0 || (int'(sh_amt) + 7) / 8 != int'(sh_dlen) ||
        sh_amt > MAX_WRITE_COUNT) begin
      expect_exception(EX_VALUE); return;
    end
    if (tbl == 0 || sh_start >= tbl || int'(sh_start) + int'(sh_amt) > tbl) begin
      expect_exception(EX_ADDRESS); return;
    end
    m = low_mask(sh_amt) << sh_start[5:0];
    if ((sh_protect & m) != 0) begin expect_exception(EX_FAILURE); return; end
    for (int k = 0; k < sh_amt; k++) begin
      v = ((k >> 3) < 8) ? sh_stage[k >> 3] : 8'h00;
      sh_coils[(int'(sh_start) + k) & 63] = v[k & 7];
    end
    echo_write();
  endfunction

  function automatic void predict_rx(input byte_t b, input logic last, input logic [63:0] di);
    int p, len;
    p = sh_pos;
    case (p)
      0: sh_slave = b;
      1: sh_code = b;
      2: sh_start[15:8] = b;
      3: sh_start[7:0] = b;
      4: sh_amt[15:8] = b;
      5: sh_amt[7:0] = b;
      6: sh_dlen = b;
      default: if (p - 7 < 8) sh_stage[p - 7] = b;
    endcase
    len = (p < POS_MAX) ? p + 1 : POS_MAX;
    sh_pos = len;
    if (!last) return;
    sh_pos = '0;
    if (len < 4) return;
    if (sh_slave != 8'd0 && sh_slave != sh_addr) return;
    case (sh_code)
      FC_READ_COILS, FC_READ_INPUTS: predict_read(len, di);
      FC_WRITE_ONE: predict_write_one(len);
      FC_WRITE_MANY: predict_write_many(len);
      default: ;
    endcase
  endfunction

  // response checker
  always @(posedge clk) begin
    rsp_byte_t e;
    if (rst_n && rsp_if.valid && rsp_if.ready) begin
      if (expected_rsp.size() == 0) begin
        report($sformatf("unexpected response byte %h", rsp_if.tx_byte));
      end else begin
        e = expected_rsp.pop_front();
        if (rsp_if.tx_byte !== e.data || rsp_if.tx_last !== e.last)
          report($sformatf("got %h/%b, want %h/%b", rsp_if.tx_byte, rsp_if.tx_last,
                           e.data, e.last));
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL modbus_coil_bank_slave");
      $finish;
    end
  end

  // receiver stalls in bursts, except while no_idle is set, when it is always ready
  initial begin
    rsp_if.ready = 1'b0;
    forever begin
      if (no_idle) begin
        rsp_if.ready <= 1'b1;
        @(posedge clk);
      end else begin
        rsp_if.ready <= 1'b1;
        repeat ($urandom_range(1, 14)) @(posedge clk);
        if ($urandom_range(0, 2) == 0) begin
          rsp_if.ready <= 1'b0;
          repeat ($urandom_range(1, 14)) @(posedge clk);
        end
      end
    end
  end

  task automatic send_byte(input byte_t b, input logic last, input logic [63:0] di);
    if (!no_idle && $urandom_range(0, 3) == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    req_if.valid <= 1'b1;
    req_if.rx_byte <= b;
    req_if.frame_end <= last;
    req_if.discrete_inputs <= di;
    do @(posedge clk); while (!req_if.ready);
    predict_rx(b, last, di);
    rx_count++;
  endtask

  task automatic send_frame(input byte_q_t f, input logic [63:0] di);
    foreach (f[i])
      send_byte(f[i], i == f.size() - 1, (i == f.size() - 1) ? di : {$urandom, $urandom});
  endtask

  task automatic go_quiet();
    req_if.valid <= 1'b0;
    wait (expected_rsp.size() == 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [63:0] value);
    go_quiet();
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr <= {idx, 3'b000};
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    case (idx)
      REG_SLAVE_ADDR: sh_addr = value[7:0];
      REG_COIL_COUNT: sh_coil_cnt = value[6:0];
      REG_INPUT_COUNT: sh_input_cnt = value[6:0];
      REG_WRITE_PROTECT: sh_protect = value;
      default: ;
    endcase
  endtask

  // request frame; dlen < 0 means byte count from the data
  function automatic byte_q_t request(input byte_t addr, input byte_t fc,
                                      input logic [15:0] start, input logic [15:0] amt,
                                      input byte_q_t data, input int dlen = -1);
    byte_q_t f;
    f = '{addr, fc, start[15:8], start[7:0], amt[15:8], amt[7:0]};
    if (fc == FC_WRITE_MANY) begin
      f.push_back((dlen < 0) ? byte_t'(data.size()) : byte_t'(dlen));
      foreach (data[i]) f.push_back(data[i]);
    end
    f.push_back(byte_t'($urandom));
    f.push_back(byte_t'($urandom));
    return f;
  endfunction

  function automatic byte_q_t rand_bytes(input int n);
    byte_q_t d;
    repeat (n) d.push_back(byte_t'($urandom));
    return d;
  endfunction

  function automatic byte_q_t random_request();
    byte_t addr, fc;
    logic [15:0] start, amt;
    byte_q_t f;
    int r;
    r = $urandom_range(0, 99);
    addr = (r < 70) ? sh_addr : (r < 85) ? 8'd0 : byte_t'($urandom);
    r = $urandom_range(0, 99);
    fc = (r < 25) ? FC_READ_COILS : (r < 45) ? FC_READ_INPUTS : (r < 65) ? FC_WRITE_ONE :
         (r < 92) ? FC_WRITE_MANY : byte_t'($urandom);
    start = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 70));
    amt = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(1, 70));
    if (fc == FC_WRITE_ONE && $urandom_range(0, 9) != 0)
      amt = $urandom_range(0, 1) ? COIL_ON : COIL_OFF;
    if (fc == FC_WRITE_MANY && amt <= 64)
      f = request(addr, fc, start, amt, rand_bytes((amt + 7) / 8));
    else
      f = request(addr, fc, start, amt, rand_bytes($urandom_range(0, 3)));
    r = $urandom_range(0, 19);
    if (r == 0) f.push_back(byte_t'($urandom));
    else if (r == 1) void'(f.pop_back());
    else if (r == 2) f = rand_bytes($urandom_range(1, 12));
    return f;
  endfunction

  task automatic test_reads();
    send_frame(request(8'd1, FC_READ_COILS, 16'd0, 16'd64, '{}), '0);
    send_frame(request(8'd1, FC_READ_INPUTS, 16'd63, 16'd1, '{}), {$urandom, $urandom});
    send_frame(request(8'd1, FC_READ_COILS, 16'd0, 16'd2001, '{}), '0);
  endtask

  task automatic test_writes();
    send_frame(request(8'd1, FC_WRITE_MANY, 16'd0, 16'd64, rand_bytes(8)), '0);
    send_frame(request(8'd1, FC_WRITE_ONE, 16'd63, COIL_ON, '{}), '0);
    send_frame(request(8'd1, FC_WRITE_MANY, 16'd3, 16'd9, rand_bytes(2), 1), '0);
  endtask

  task automatic test_special_frames();
    send_frame(request(8'd7, FC_READ_COILS, 16'd0, 16'd8, '{}), '0);
    send_frame(request(8'd0, FC_WRITE_ONE, 16'd1, COIL_ON, '{}), '0);
    send_frame('{8'd1, FC_READ_COILS, 8'd0}, '0);
    send_frame(request(8'd1, 8'd3, 16'd0, 16'd1, '{}), '0);
  endtask

  task automatic test_config();
    write_reg(REG_SLAVE_ADDR, 64'd247);
    write_reg(REG_WRITE_PROTECT, 64'h8000_0000_0000_0010);
    send_frame(request(8'd247, FC_WRITE_ONE, 16'd4, COIL_ON, '{}), '0);
    send_frame(request(8'd247, FC_WRITE_MANY, 16'd60, 16'd4, rand_bytes(1)), '0);
    write_reg(REG_COIL_COUNT, 64'd0);
    write_reg(REG_INPUT_COUNT, 64'd127);
    send_frame(request(8'd247, FC_READ_COILS, 16'd0, 16'd1, '{}), '0);
    send_frame(request(8'd247, FC_READ_INPUTS, 16'd0, 16'd64, '{}), {$urandom, $urandom});
  endtask

  task automatic test_random();
    int target;
    for (int ph = 0; ph < 3; ph++) begin
      write_reg(REG_SLAVE_ADDR, (ph == 0) ? 64'd1 : 64'($urandom_range(1, 247)));
      write_reg(REG_COIL_COUNT, (ph == 1) ? 64'd127 :
                $urandom_range(0, 3) ? 64'($urandom_range(40, 64)) : 64'($urandom_range(0, 127)));
      write_reg(REG_INPUT_COUNT, 64'($urandom_range(0, 127)));
      write_reg(REG_WRITE_PROTECT,
                ($urandom_range(0, 1) ? '0 : ({$urandom, $urandom} & {$urandom, $urandom}
                                              & {$urandom, $urandom})));
      no_idle = (ph == 2);
      target = rx_count + 10;
      while (rx_count < target) send_frame(random_request(), {$urandom, $urandom});
    end
  endtask

  initial begin
    req_if.valid = 1'b0;
    req_if.rx_byte = '0;
    req_if.frame_end = 1'b0;
    req_if.discrete_inputs = '0;
    sh_addr = 8'd1;
    sh_coil_cnt = 7'd64;
    sh_input_cnt = 7'd64;
    sh_protect = '0;
    sh_coils = '0;
    sh_pos = '0;
    sh_slave = '0;
    sh_code = '0;
    sh_start = '0;
    sh_amt = '0;
    sh_dlen = '0;
    foreach (sh_stage[i]) sh_stage[i] = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reads();
    test_writes();
    test_special_frames();
    test_config();
    test_random();
    go_quiet();
    if (errors == 0) begin
      $display("PASS modbus_coil_bank_slave");
    end else begin
      $display("FAIL modbus_coil_bank_slave");
    end
    $finish;
  end

endmodule
